// ----- design/wbmmr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbmmr_pkg: shared definitions of the waveform bucket summary block
// Widths, register indexes, state types and the word that travels from the
// accumulating front end, through the queue, to the root-mean-square unit.
// ----------------------------------------------------------------------------
package wbmmr_pkg;

  // Track partitioning.
  localparam int BUCKETS      = 2048;
  localparam int BUCKET_W     = 11;             // log2 of BUCKETS
  localparam int CB_W         = BUCKET_W + 1;   // span counter, holds BUCKETS itself
  localparam int MAX_CHANNELS = 8;
  localparam int CHAN_W       = 3;
  localparam int CC_W         = 4;

  // Datapath widths.
  localparam int FRAME_W  = 41;
  localparam int SAMPLE_W = 24;
  localparam int SQ_SHIFT = 14;
  localparam int SQ_W     = 32;
  localparam int SUM_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int RMS_W    = 17;
  localparam int SPAN_W   = CB_W + FRAME_W - BUCKET_W;  // span end bound
  localparam int JNUM_W   = FRAME_W + BUCKET_W + 1;     // relocation dividend
  localparam int QUO_W    = CB_W;                       // relocation quotient

  // Configuration port.
  localparam int CFG_W     = 41;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'b1;
  localparam logic [FRAME_W-1:0]   TOTAL_FRAMES_RST  = 41'd2048;
  localparam logic [CC_W-1:0]      CHANNEL_COUNT_RST = 4'd2;

  // Accumulator reset values.
  localparam logic signed [SAMPLE_W-1:0] MIN_RESET = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] MAX_RESET = 24'sh800000;

  // Queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_LVL_W = 3;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SETTLE,
    F_EVAL,
    F_DIV,
    F_EMIT
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_SQRT,
    B_OUT
  } back_state_e;

  // One channel summary of a closed span.
  typedef struct packed {
    logic [BUCKET_W-1:0]        bucket;
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] maximum;
    logic [SUM_W-1:0]           square_sum;
    logic [FRAME_W-1:0]         span_len;
    logic                       last_bucket;
    logic                       last_track;
  } span_word_t;

  typedef struct packed {
    logic [Q_LVL_W-1:0] level;
    logic               full;
    logic               empty;
  } queue_stat_t;

endpackage

// ----- design/wbmmr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbmmr_front: sample intake and per-channel accumulation
// Holds the configuration, the track counters and the per-channel minimum,
// maximum and square sum. Relocates the span with a small iterative divider
// where the current span does not hold the frame, and hands one word per
// channel to the queue when a span closes.
// ----------------------------------------------------------------------------
module wbmmr_front
  import wbmmr_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       track_start_i,
  output logic                       push_valid_o,
  input  logic                       push_stall_i,
  output span_word_t                 push_word_o
);

  front_state_e state_q, state_d;

  logic [FRAME_W-1:0] tf_q;
  logic [CC_W-1:0]    cc_q;
  logic [CC_W-1:0]    cc_eff;

  logic [FRAME_W-1:0] fd_q, fd_d;
  logic [CB_W-1:0]    cb_q, cb_d;
  logic [FRAME_W-1:0] bff_q, bff_d;
  logic [CHAN_W-1:0]  pos_q, pos_d;

  logic signed [SAMPLE_W-1:0] min_q [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] min_d [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] max_q [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] max_d [MAX_CHANNELS];
  logic [SUM_W-1:0]           sum_q [MAX_CHANNELS];
  logic [SUM_W-1:0]           sum_d [MAX_CHANNELS];

  logic signed [SAMPLE_W-1:0] smp_q, smp_d;
  logic [SQ_W-1:0]            sq_q, sq_d;
  logic [SPAN_W-1:0]          span_end_q;

  logic [JNUM_W-1:0] rem_q, rem_d;
  logic [JNUM_W-1:0] dvs_q, dvs_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [3:0]        dcnt_q, dcnt_d;

  logic [CHAN_W-1:0]   emit_cnt_q, emit_cnt_d;
  logic [BUCKET_W-1:0] emit_bucket_q, emit_bucket_d;
  logic [FRAME_W-1:0]  emit_len_q, emit_len_d;
  logic                emit_last_q, emit_last_d;

  logic                         in_fire;
  logic signed [2*SAMPLE_W-1:0] sq_prod;
  logic [2*SAMPLE_W-SQ_SHIFT-1:0] sq_full;
  logic [CB_W-1:0]              cb_inc;
  logic [CB_W+FRAME_W-1:0]      span_prod;
  logic [FRAME_W-1:0]           fd_inc;
  logic [CC_W-1:0]              pos_inc;
  logic                         past_end;
  logic                         need_jump;
  logic                         frame_end;
  logic                         closing;
  logic                         emit_last;
  logic                         dtake;
  logic [QUO_W-1:0]             quo_next;
  logic [JNUM_W-1:0]            jump_num;
  logic [CHAN_W-1:0]            rd_idx;
  logic signed [SAMPLE_W-1:0]   rd_min, rd_max, new_min, new_max;
  logic [SUM_W-1:0]             rd_sum, new_sum;
  logic [SUM_W:0]               sum_ext;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tf_q <= TOTAL_FRAMES_RST;
      cc_q <= CHANNEL_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TOTAL_FRAMES:  tf_q <= cfg_wdata_i[FRAME_W-1:0];
        CFG_CHANNEL_COUNT: cc_q <= cfg_wdata_i[CC_W-1:0];
        default: ;
      endcase
    end
  end

  // A count of zero means one channel; counts above the store depth clamp.
  always_comb begin
    if (cc_q == '0) begin
      cc_eff = CC_W'(1);
    end else if (cc_q > CC_W'(MAX_CHANNELS)) begin
      cc_eff = CC_W'(MAX_CHANNELS);
    end else begin
      cc_eff = cc_q;
    end
  end

  // Intake handshake and the registered square of the incoming sample.
  assign in_stall_o = (state_q != F_IDLE);
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign sq_prod    = sample_i * sample_i;
  assign sq_full    = sq_prod[2*SAMPLE_W-1:SQ_SHIFT];
  assign sq_d       = (|sq_full[2*SAMPLE_W-SQ_SHIFT-1:SQ_W]) ? '1 : sq_full[SQ_W-1:0];
  assign smp_d      = sample_i;

  // End frame of the current span, registered after the multiplier.
  assign cb_inc    = cb_q + CB_W'(1);
  assign span_prod = (CB_W+FRAME_W)'(cb_inc) * (CB_W+FRAME_W)'(tf_q);

  // Decisions taken while a held sample is evaluated.
  assign fd_inc    = fd_q + FRAME_W'(1);
  assign pos_inc   = CC_W'(pos_q) + CC_W'(1);
  assign past_end  = (fd_q >= tf_q);
  assign need_jump = (pos_q == '0) &&
                     ((cb_q >= CB_W'(BUCKETS)) || (span_end_q <= SPAN_W'(fd_q)));
  assign frame_end = (pos_inc >= cc_eff);
  assign closing   = frame_end && (cb_q < CB_W'(BUCKETS)) &&
                     (SPAN_W'(fd_inc) == span_end_q);
  assign emit_last = ((CC_W'(emit_cnt_q) + CC_W'(1)) == cc_eff);

  // Relocation divider step: one quotient bit per cycle.
  assign dtake    = (rem_q >= dvs_q);
  assign quo_next = {quo_q[QUO_W-2:0], dtake};
  assign jump_num = ((JNUM_W'(fd_q) + JNUM_W'(1)) << BUCKET_W) +
                    JNUM_W'(tf_q) - JNUM_W'(1);

  // Single read port on the channel stores, shared by update and emission.
  assign rd_idx  = (state_q == F_EMIT) ? emit_cnt_q : pos_q;
  assign rd_min  = min_q[rd_idx];
  assign rd_max  = max_q[rd_idx];
  assign rd_sum  = sum_q[rd_idx];
  assign new_min = (smp_q < rd_min) ? smp_q : rd_min;
  assign new_max = (smp_q > rd_max) ? smp_q : rd_max;
  assign sum_ext = {1'b0, rd_sum} + (SUM_W+1)'(sq_q);
  assign new_sum = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_fire) begin
          state_d = track_start_i ? F_SETTLE : F_EVAL;
        end
      end
      F_SETTLE: state_d = F_EVAL;
      F_EVAL: begin
        priority if (past_end) begin
          state_d = F_IDLE;
        end else if (need_jump) begin
          state_d = F_DIV;
        end else if (closing) begin
          state_d = F_EMIT;
        end else begin
          state_d = F_IDLE;
        end
      end
      F_DIV: begin
        if (dcnt_q == '0) begin
          state_d = F_SETTLE;
        end
      end
      F_EMIT: begin
        if (!push_stall_i && emit_last) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // Counters, stores and the divider.
  always_comb begin
    fd_d          = fd_q;
    cb_d          = cb_q;
    bff_d         = bff_q;
    pos_d         = pos_q;
    min_d         = min_q;
    max_d         = max_q;
    sum_d         = sum_q;
    rem_d         = rem_q;
    dvs_d         = dvs_q;
    quo_d         = quo_q;
    dcnt_d        = dcnt_q;
    emit_cnt_d    = emit_cnt_q;
    emit_bucket_d = emit_bucket_q;
    emit_len_d    = emit_len_q;
    emit_last_d   = emit_last_q;
    unique case (state_q)
      F_IDLE: begin
        // A track start clears the counters before its own sample.
        if (in_fire && track_start_i) begin
          fd_d  = '0;
          cb_d  = '0;
          bff_d = '0;
          pos_d = '0;
          for (int c = 0; c < MAX_CHANNELS; c++) begin
            min_d[c] = MIN_RESET;
            max_d[c] = MAX_RESET;
            sum_d[c] = '0;
          end
        end
      end
      F_EVAL: begin
        if (!past_end && need_jump) begin
          rem_d  = jump_num;
          dvs_d  = JNUM_W'(tf_q) << (QUO_W - 1);
          quo_d  = '0;
          dcnt_d = 4'(QUO_W - 1);
        end else if (!past_end) begin
          min_d[pos_q] = new_min;
          max_d[pos_q] = new_max;
          sum_d[pos_q] = new_sum;
          if (!frame_end) begin
            pos_d = pos_q + CHAN_W'(1);
          end else begin
            pos_d = '0;
            fd_d  = fd_inc;
            if (closing) begin
              emit_cnt_d    = '0;
              emit_bucket_d = cb_q[BUCKET_W-1:0];
              emit_len_d    = fd_inc - bff_q;
              emit_last_d   = (fd_inc == tf_q);
              cb_d          = cb_inc;
              bff_d         = fd_inc;
            end
          end
        end
      end
      F_DIV: begin
        rem_d  = dtake ? (rem_q - dvs_q) : rem_q;
        dvs_d  = dvs_q >> 1;
        quo_d  = quo_next;
        dcnt_d = dcnt_q - 4'd1;
        if (dcnt_q == '0) begin
          // First span whose end lies beyond this frame.
          cb_d  = quo_next - QUO_W'(1);
          bff_d = fd_q;
        end
      end
      F_EMIT: begin
        if (!push_stall_i) begin
          if (emit_last) begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
              min_d[c] = MIN_RESET;
              max_d[c] = MAX_RESET;
              sum_d[c] = '0;
            end
          end else begin
            emit_cnt_d = emit_cnt_q + CHAN_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Words towards the queue.
  always_comb begin
    push_valid_o            = (state_q == F_EMIT);
    push_word_o.bucket      = emit_bucket_q;
    push_word_o.channel     = emit_cnt_q;
    push_word_o.minimum     = rd_min;
    push_word_o.maximum     = rd_max;
    push_word_o.square_sum  = rd_sum;
    push_word_o.span_len    = emit_len_q;
    push_word_o.last_bucket = emit_last;
    push_word_o.last_track  = emit_last_q;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      fd_q       <= '0;
      cb_q       <= '0;
      bff_q      <= '0;
      pos_q      <= '0;
      emit_cnt_q <= '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        min_q[c] <= MIN_RESET;
        max_q[c] <= MAX_RESET;
        sum_q[c] <= '0;
      end
    end else begin
      state_q    <= state_d;
      fd_q       <= fd_d;
      cb_q       <= cb_d;
      bff_q      <= bff_d;
      pos_q      <= pos_d;
      emit_cnt_q <= emit_cnt_d;
      min_q      <= min_d;
      max_q      <= max_d;
      sum_q      <= sum_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      smp_q <= smp_d;
      sq_q  <= sq_d;
    end
    span_end_q    <= span_prod[CB_W+FRAME_W-1:BUCKET_W];
    rem_q         <= rem_d;
    dvs_q         <= dvs_d;
    quo_q         <= quo_d;
    dcnt_q        <= dcnt_d;
    emit_bucket_q <= emit_bucket_d;
    emit_len_q    <= emit_len_d;
    emit_last_q   <= emit_last_d;
  end

endmodule

// ----- design/wbmmr_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbmmr_queue: short queue of span words
// Decouples the accumulating front end from the root-mean-square unit.
// ----------------------------------------------------------------------------
module wbmmr_queue
  import wbmmr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_stall_o,
  input  span_word_t  push_word_i,
  output logic        pop_valid_o,
  input  logic        pop_stall_i,
  output span_word_t  pop_word_o,
  output queue_stat_t stat_o
);

  span_word_t         mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_LVL_W-1:0] level_q;
  logic               push_fire, pop_fire;
  logic               full, empty;

  assign full      = (level_q == Q_LVL_W'(Q_DEPTH));
  assign empty     = (level_q == '0);
  assign push_fire = push_valid_i & ~full;
  assign pop_fire  = ~empty & ~pop_stall_i;

  assign push_stall_o = full;
  assign pop_valid_o  = ~empty;
  assign pop_word_o   = mem_q[rd_ptr_q];

  assign stat_o.level = level_q;
  assign stat_o.full  = full;
  assign stat_o.empty = empty;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (pop_fire) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
        level_q <= level_q + Q_LVL_W'(1);
      end else if (!push_fire && pop_fire) begin
        level_q <= level_q - Q_LVL_W'(1);
      end
    end
  end

  // Word storage.
  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

// ----- design/wbmmr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbmmr_back: mean square and root unit
// Divides the square sum by the span length one bit a cycle, takes the
// integer square root two radicand bits a cycle, and holds the result word.
// ----------------------------------------------------------------------------
module wbmmr_back
  import wbmmr_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       pop_valid_i,
  output logic                       pop_stall_o,
  input  span_word_t                 pop_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [BUCKET_W-1:0]        bucket_index_o,
  output logic [CHAN_W-1:0]          channel_o,
  output logic signed [SAMPLE_W-1:0] minimum_o,
  output logic signed [SAMPLE_W-1:0] maximum_o,
  output logic [RMS_W-1:0]           rms_o,
  output logic                       last_of_bucket_o,
  output logic                       last_of_track_o
);

  back_state_e state_q, state_d;

  span_word_t          word_q;
  logic [SUM_W-1:0]    dvd_q;
  logic [FRAME_W-1:0]  drem_q;
  logic [5:0]          dcnt_q;
  logic [SUM_W-1:0]    rad_q;
  logic [ROOT_W+1:0]   srem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [4:0]          scnt_q;

  logic                take;
  logic [FRAME_W:0]    dtrial;
  logic                dbit;
  logic [ROOT_W+3:0]   strial;
  logic [ROOT_W+1:0]   sgoal;
  logic                sbit;

  assign pop_stall_o = (state_q != B_IDLE);
  assign take        = pop_valid_i & ~pop_stall_o;

  // Restoring division step.
  assign dtrial = {drem_q, dvd_q[SUM_W-1]};
  assign dbit   = (dtrial >= {1'b0, word_q.span_len});

  // Square root step on the next two radicand bits.
  assign strial = {srem_q, rad_q[SUM_W-1:SUM_W-2]};
  assign sgoal  = {root_q, 2'b01};
  assign sbit   = (strial >= (ROOT_W+4)'(sgoal));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (take) begin
          // A zero length span has a mean of zero.
          state_d = (pop_word_i.span_len == '0) ? B_SQRT : B_DIV;
        end
      end
      B_DIV: begin
        if (dcnt_q == '0) begin
          state_d = B_SQRT;
        end
      end
      B_SQRT: begin
        if (scnt_q == '0) begin
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_stall_i) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Result word.
  always_comb begin
    out_valid_o      = (state_q == B_OUT);
    bucket_index_o   = word_q.bucket;
    channel_o        = word_q.channel;
    minimum_o        = word_q.minimum;
    maximum_o        = word_q.maximum;
    rms_o            = root_q[RMS_W-1:0];
    last_of_bucket_o = word_q.last_bucket;
    last_of_track_o  = word_q.last_track;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        if (take) begin
          word_q <= pop_word_i;
          dvd_q  <= pop_word_i.square_sum;
          drem_q <= '0;
          dcnt_q <= 6'(SUM_W - 1);
          rad_q  <= '0;
          srem_q <= '0;
          root_q <= '0;
          scnt_q <= 5'(ROOT_W - 1);
        end
      end
      B_DIV: begin
        drem_q <= dbit ? FRAME_W'(dtrial - {1'b0, word_q.span_len})
                       : dtrial[FRAME_W-1:0];
        dvd_q  <= {dvd_q[SUM_W-2:0], dbit};
        dcnt_q <= dcnt_q - 6'd1;
        if (dcnt_q == '0) begin
          rad_q <= {dvd_q[SUM_W-2:0], dbit};
        end
      end
      B_SQRT: begin
        srem_q <= sbit ? (ROOT_W+2)'(strial - (ROOT_W+4)'(sgoal))
                       : strial[ROOT_W+1:0];
        root_q <= {root_q[ROOT_W-2:0], sbit};
        rad_q  <= rad_q << 2;
        scnt_q <= scnt_q - 5'd1;
      end
      B_OUT: ;
      default: ;
    endcase
  end

endmodule

// ----- design/waveform_bucket_min_max_rms.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_bucket_min_max_rms: per-span minimum, maximum and RMS overview
// Splits an interleaved multichannel track into 2048 spans and reports, for
// every channel of each closed span, the extremes and the RMS level.
//
//   Channel  Direction  Handshake               Word
//   in       sink       in_valid_i / in_stall_o  sample_i, track_start_i
//   out      source     out_valid_o / out_stall_i bucket_index_o .. last_of_track_o
//   cfg      sink       cfg_we_i                 cfg_index_i, cfg_wdata_i
//
// A sample goes through intake, then the store update; a track start adds the
// settling state, and a span relocation adds one divider step per quotient bit,
// settling for the span end multiplier and a second evaluation. A closing span
// hands one word per channel to a four-entry queue. The back end gives each
// word one division step per square sum bit and one root step per root bit; a
// zero length span skips the division. Reset clears the control state, counters
// and channel stores at once; there is no clearing pass. A stalled output holds
// the back end, and the front end keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
module waveform_bucket_min_max_rms
  import wbmmr_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       track_start_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [BUCKET_W-1:0]        bucket_index_o,
  output logic [CHAN_W-1:0]          channel_o,
  output logic signed [SAMPLE_W-1:0] minimum_o,
  output logic signed [SAMPLE_W-1:0] maximum_o,
  output logic [RMS_W-1:0]           rms_o,
  output logic                       last_of_bucket_o,
  output logic                       last_of_track_o
);

  logic        push_valid, push_stall;
  span_word_t  push_word;
  logic        pop_valid, pop_stall;
  span_word_t  pop_word;
  queue_stat_t q_stat;

  // Intake and accumulation.
  wbmmr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .track_start_i (track_start_i),
    .push_valid_o  (push_valid),
    .push_stall_i  (push_stall),
    .push_word_o   (push_word)
  );

  // Span word queue.
  wbmmr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_stall_o (push_stall),
    .push_word_i  (push_word),
    .pop_valid_o  (pop_valid),
    .pop_stall_i  (pop_stall),
    .pop_word_o   (pop_word),
    .stat_o       (q_stat)
  );

  // Mean square and root.
  wbmmr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pop_valid_i      (pop_valid),
    .pop_stall_o      (pop_stall),
    .pop_word_i       (pop_word),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .bucket_index_o   (bucket_index_o),
    .channel_o        (channel_o),
    .minimum_o        (minimum_o),
    .maximum_o        (maximum_o),
    .rms_o            (rms_o),
    .last_of_bucket_o (last_of_bucket_o),
    .last_of_track_o  (last_of_track_o)
  );

  // The front end never takes a sample while it is handing span words over.
  a_no_intake_while_emitting: assert property (
    @(posedge clk_i) disable iff (!rst_ni) push_valid |-> in_stall_o
  ) else $error("sample intake open while span words are emitted");

  // A full queue holds exactly its depth in words.
  a_queue_level: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> (q_stat.level == Q_LVL_W'(Q_DEPTH)) && !q_stat.empty
  ) else $error("queue level disagrees with its full flag");

  // The back end works on one word at a time.
  a_back_single_word: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (pop_valid && !pop_stall) |=> pop_stall
  ) else $error("back end took a second word while busy");

  // A delivered result is followed by a fresh computation, never an instant result.
  a_no_back_to_back_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (out_valid_o && !out_stall_i) |=> !out_valid_o
  ) else $error("result appeared without a root computation");

endmodule
